/* design/tfa_pkg.sv */
// tfa_pkg: sizes, payload structs and register codes shared by the
// temporal frame averager. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tfa_pkg;

	// sizes of the pixel store and of the averaging span
	localparam int unsigned MAX_PIXELS = 2097152;
	localparam int unsigned MAX_SPAN   = 65536;

	localparam int unsigned PIX_W    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int unsigned FPE_W    = PIX_W + 1;
	localparam int unsigned N_W      = $clog2(MAX_SPAN) + 1;
	localparam int unsigned FRAME_W  = 24;
	localparam int unsigned FP_W     = 22;
	localparam int unsigned SUM_W    = 24;
	localparam int unsigned CH_W     = 8;
	localparam int unsigned FRAMES_W = 17;
	localparam int unsigned CFG_W    = 24;
	localparam int unsigned IDX_W    = 2;

	// result queue behind the divider pipeline
	localparam int unsigned FIFO_DEPTH = 16;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = FIFO_AW + 1;

	typedef enum logic [IDX_W-1:0] {
		REG_START_FRAME  = 2'd0,
		REG_END_FRAME    = 2'd1,
		REG_FRAME_PIXELS = 2'd2
	} reg_idx_t;

	// one pixel on its way into the sum store
	typedef struct packed {
		logic [PIX_W-1:0] addr;
		logic             first;
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  red;
		logic [N_W-1:0]   n;
		logic             eof;
	} store_req_t;

	// updated sums on their way into the divider
	typedef struct packed {
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] red;
		logic [N_W-1:0]   n;
		logic             eof;
	} sums_t;

	// finished result
	typedef struct packed {
		logic [CH_W-1:0]     avg_blue;
		logic [CH_W-1:0]     avg_green;
		logic [CH_W-1:0]     avg_red;
		logic [FRAMES_W-1:0] frames;
		logic                eof;
	} result_t;

endpackage

`default_nettype wire

/* design/tfa_if.sv */
// tfa_if: valid/ready channels of the temporal frame averager (pixel input,
// average output, register writes). Depends on tfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tfa_pix_if import tfa_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink (input valid, input blue, input green, input red, output ready);
endinterface

interface tfa_avg_if import tfa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CH_W-1:0]     avg_blue;
	logic [CH_W-1:0]     avg_green;
	logic [CH_W-1:0]     avg_red;
	logic [FRAMES_W-1:0] frames_averaged;
	logic                end_of_frame;

	modport source (output valid, output avg_blue, output avg_green, output avg_red,
		output frames_averaged, output end_of_frame, input ready);
	modport sink (input valid, input avg_blue, input avg_green, input avg_red,
		input frames_averaged, input end_of_frame, output ready);
endinterface

interface tfa_cfg_if import tfa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/tfa_sum_store.sv */
// tfa_sum_store: per-pixel sum memory with read-modify-write and a bypass
// for back-to-back updates of one entry. Depends on tfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfa_sum_store import tfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  store_req_t req,
	output logic       sums_valid,
	output sums_t      sums
);

	localparam int unsigned ROW_W = 3 * SUM_W;

	logic [ROW_W-1:0] mem [MAX_PIXELS];

	logic             valid_s1;
	store_req_t       req_s1;
	logic [ROW_W-1:0] rd_data_s1;
	logic             fwd_s1;
	logic [ROW_W-1:0] fwd_data_s1;
	logic [ROW_W-1:0] merged;
	logic [ROW_W-1:0] wr_data;
	logic             valid_s2;
	sums_t            sums_s2;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req_valid;
			// the entry written now is the one read now: the read sees old data
			fwd_s1   <= valid_s1 && (req_s1.addr == req.addr);
			valid_s2 <= valid_s1;
		end
	end

	// memory read and write-back
	always_ff @(posedge clk) begin
		if (req_valid) begin
			rd_data_s1 <= mem[req.addr];
		end
		if (valid_s1) begin
			mem[req_s1.addr] <= wr_data;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		req_s1      <= req;
		fwd_data_s1 <= wr_data;
		sums_s2     <= '{blue: wr_data[3*SUM_W-1:2*SUM_W], green: wr_data[2*SUM_W-1:SUM_W],
			red: wr_data[SUM_W-1:0], n: req_s1.n, eof: req_s1.eof};
	end

	// first used frame loads, later frames add with wrap
	always_comb begin
		merged = fwd_s1 ? fwd_data_s1 : rd_data_s1;
		if (req_s1.first) begin
			wr_data = {SUM_W'(req_s1.blue), SUM_W'(req_s1.green), SUM_W'(req_s1.red)};
		end else begin
			wr_data[3*SUM_W-1:2*SUM_W] = merged[3*SUM_W-1:2*SUM_W] + SUM_W'(req_s1.blue);
			wr_data[2*SUM_W-1:SUM_W]   = merged[2*SUM_W-1:SUM_W] + SUM_W'(req_s1.green);
			wr_data[SUM_W-1:0]         = merged[SUM_W-1:0] + SUM_W'(req_s1.red);
		end
	end

	assign sums_valid = valid_s2;
	assign sums       = sums_s2;

endmodule

`default_nettype wire

/* design/tfa_divider.sv */
// tfa_divider: pipelined restoring divider, one quotient bit per stage for
// all three channels, rounding to nearest even with saturation. Depends on tfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfa_divider import tfa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  sums_t   in_sums,
	output logic    out_valid,
	output result_t out_res
);

	localparam int unsigned REM_W = N_W;
	localparam int unsigned CMP_W = (SUM_W > N_W + CH_W) ? SUM_W : N_W + CH_W;

	typedef struct packed {
		logic             sat;
		logic [REM_W-1:0] rem;
		logic [CH_W-1:0]  low;
		logic [CH_W-1:0]  quo;
	} lane_t;

	// saturation test and partial remainder from the high sum bits
	function automatic lane_t lane_init(input logic [SUM_W-1:0] sum, input logic [N_W-1:0] n);
		lane_t            l;
		logic [CMP_W-1:0] bound;
		bound = CMP_W'({n, {CH_W{1'b0}}});
		l.sat = CMP_W'(sum) >= bound;
		l.rem = REM_W'(sum >> CH_W);
		l.low = sum[CH_W-1:0];
		l.quo = '0;
		return l;
	endfunction

	// one restoring step
	function automatic lane_t lane_step(input lane_t l, input logic [N_W-1:0] n);
		lane_t          r;
		logic [REM_W:0] trial;
		logic           ge;
		trial = {l.rem, l.low[CH_W-1]};
		ge    = trial >= {1'b0, n};
		r     = l;
		r.rem = ge ? REM_W'(trial - {1'b0, n}) : REM_W'(trial);
		r.low = {l.low[CH_W-2:0], 1'b0};
		r.quo = {l.quo[CH_W-2:0], ge};
		return r;
	endfunction

	// round half to even, clip at full scale
	function automatic logic [CH_W-1:0] lane_round(input lane_t l, input logic [N_W-1:0] n);
		logic [REM_W:0] twice;
		logic           up;
		twice = {l.rem, 1'b0};
		up    = (twice > {1'b0, n}) || ((twice == {1'b0, n}) && l.quo[0]);
		if (l.sat || (up && (&l.quo))) begin
			return '1;
		end
		return l.quo + CH_W'(up);
	endfunction

	lane_t          lane_s  [0:CH_W][0:2];
	logic           valid_s [0:CH_W];
	logic [N_W-1:0] n_s     [0:CH_W];
	logic           eof_s   [0:CH_W];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		lane_s[0][0] <= lane_init(in_sums.blue, in_sums.n);
		lane_s[0][1] <= lane_init(in_sums.green, in_sums.n);
		lane_s[0][2] <= lane_init(in_sums.red, in_sums.n);
		n_s[0]       <= in_sums.n;
		eof_s[0]     <= in_sums.eof;
	end

	// quotient bit stages
	for (genvar k = 1; k <= CH_W; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			for (int c = 0; c < 3; c++) begin
				lane_s[k][c] <= lane_step(lane_s[k-1][c], n_s[k-1]);
			end
			n_s[k]   <= n_s[k-1];
			eof_s[k] <= eof_s[k-1];
		end
	end

	// rounding on the way out
	assign out_valid         = valid_s[CH_W];
	assign out_res.avg_blue  = lane_round(lane_s[CH_W][0], n_s[CH_W]);
	assign out_res.avg_green = lane_round(lane_s[CH_W][1], n_s[CH_W]);
	assign out_res.avg_red   = lane_round(lane_s[CH_W][2], n_s[CH_W]);
	assign out_res.frames    = FRAMES_W'(n_s[CH_W]);
	assign out_res.eof       = eof_s[CH_W];

endmodule

`default_nettype wire

/* design/tfa_out_fifo.sv */
// tfa_out_fifo: small result queue that decouples the divider pipeline from
// the output handshake. Depends on tfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfa_out_fifo import tfa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    out_valid,
	output result_t out_data
);

	result_t            entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

/* design/temporal_frame_average.sv */
// channel   dir  transfer when        payload
// cfg       in   valid & ready        index, data (start_frame, end_frame, frame_pixels)
// pixels    in   valid & ready        blue, green, red
// averages  out  valid & ready        avg_blue, avg_green, avg_red, frames_averaged,
//                                     end_of_frame
//
// One pixel per clock while pixels.ready is high; a result passes two sum memory
// stages, divider entry, eight quotient-bit stages and the result queue.
// The pipeline never stalls; a 16-entry result queue holds results while averages
// is back-pressured, and pixels.ready drops once 16 results are owed.
// Reset clears counters, queue and registers (frame_pixels to 1), not the sum memory:
// the first used frame writes each entry before it is used. cfg.ready is always high.
//
// Top level of the temporal frame averager. Depends on tfa_pkg, tfa_if,
// tfa_sum_store, tfa_divider and tfa_out_fifo.
`timescale 1ns / 1ps
`default_nettype none

module temporal_frame_average import tfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tfa_cfg_if.sink   cfg,
	tfa_pix_if.sink   pixels,
	tfa_avg_if.source averages
);

	logic [FRAME_W-1:0] start_frame_q;
	logic [FRAME_W-1:0] end_frame_q;
	logic [FP_W-1:0]    frame_pixels_q;
	logic [PIX_W-1:0]   pixel_position_q;
	logic [FRAME_W-1:0] frame_number_q;
	logic [CNT_W-1:0]   credit_q;

	logic [FPE_W-1:0]   fp_eff;
	logic               eof;
	logic [FRAME_W:0]   span_end;
	logic [FRAME_W:0]   last_used;
	logic               used;
	logic [FRAME_W-1:0] offset;
	logic               accept;
	logic               issue;
	logic               out_xfer;
	store_req_t         req;
	logic               sums_valid;
	sums_t              sums;
	logic               res_valid;
	result_t            res;
	logic               q_valid;
	result_t            q_data;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_frame_q  <= '0;
			end_frame_q    <= '0;
			frame_pixels_q <= FP_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (reg_idx_t'(cfg.index))
				REG_START_FRAME:  start_frame_q  <= cfg.data[FRAME_W-1:0];
				REG_END_FRAME:    end_frame_q    <= cfg.data[FRAME_W-1:0];
				REG_FRAME_PIXELS: frame_pixels_q <= cfg.data[FP_W-1:0];
				default:          ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// frame geometry and range test for the pixel at the input
	always_comb begin
		if (frame_pixels_q == '0) begin
			fp_eff = FPE_W'(1);
		end else if (32'(frame_pixels_q) > MAX_PIXELS) begin
			fp_eff = FPE_W'(MAX_PIXELS);
		end else begin
			fp_eff = FPE_W'(frame_pixels_q);
		end
		eof       = (FPE_W'(pixel_position_q) + FPE_W'(1)) >= fp_eff;
		span_end  = {1'b0, start_frame_q} + (FRAME_W + 1)'(MAX_SPAN - 1);
		last_used = ({1'b0, end_frame_q} < span_end) ? {1'b0, end_frame_q} : span_end;
		used      = (frame_number_q >= start_frame_q) && ({1'b0, frame_number_q} <= last_used);
		offset    = frame_number_q - start_frame_q;
	end

	assign accept = pixels.valid && pixels.ready;
	assign issue  = accept && used;

	assign req.addr  = pixel_position_q;
	assign req.first = (offset == '0);
	assign req.blue  = pixels.blue;
	assign req.green = pixels.green;
	assign req.red   = pixels.red;
	assign req.n     = N_W'(offset) + N_W'(1);
	assign req.eof   = eof;

	// pixel and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_position_q <= '0;
			frame_number_q   <= '0;
		end else if (accept) begin
			if (eof) begin
				pixel_position_q <= '0;
				frame_number_q   <= frame_number_q + FRAME_W'(1);
			end else begin
				pixel_position_q <= pixel_position_q + PIX_W'(1);
			end
		end
	end

	// results owed: never more than the queue can hold
	assign out_xfer = averages.valid && averages.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			unique case ({issue, out_xfer})
				2'b10:   credit_q <= credit_q + CNT_W'(1);
				2'b01:   credit_q <= credit_q - CNT_W'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	assign pixels.ready = (credit_q < CNT_W'(FIFO_DEPTH));

	tfa_sum_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (issue),
		.req        (req),
		.sums_valid (sums_valid),
		.sums       (sums)
	);

	tfa_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sums_valid),
		.in_sums   (sums),
		.out_valid (res_valid),
		.out_res   (res)
	);

	tfa_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (out_xfer),
		.out_valid (q_valid),
		.out_data  (q_data)
	);

	// output channel
	assign averages.valid           = q_valid;
	assign averages.avg_blue        = q_data.avg_blue;
	assign averages.avg_green       = q_data.avg_green;
	assign averages.avg_red         = q_data.avg_red;
	assign averages.frames_averaged = q_data.frames;
	assign averages.end_of_frame    = q_data.eof;

endmodule

`default_nettype wire

/* design/tfa_checker.sv */
// tfa_checker: port-level assertions for the temporal frame averager, bound
// to the top level. Depends on tfa_pkg and temporal_frame_average.
`timescale 1ns / 1ps
`default_nettype none

module tfa_checker import tfa_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [CH_W-1:0]     avg_blue,
	input logic [CH_W-1:0]     avg_green,
	input logic [CH_W-1:0]     avg_red,
	input logic [FRAMES_W-1:0] frames,
	input logic                eof
);

	logic [15:0] pend_q;
	logic        ovf_q;
	logic        in_xfer;
	logic        out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// pixels taken minus results given, sticky flag once it wraps past its top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			unique case ({in_xfer, out_xfer})
				2'b10: begin
					pend_q <= pend_q + 16'd1;
					if (&pend_q) begin
						ovf_q <= 1'b1;
					end
				end
				2'b01:   pend_q <= pend_q - 16'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_frames_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frames != '0) && (32'(frames) <= MAX_SPAN))
		else $error("frames_averaged out of range");

	a_result_has_pixel: assert property (@(posedge clk) disable iff (!arst_n || ovf_q)
		out_xfer |-> (pend_q != '0))
		else $error("result transfer without an earlier pixel");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(avg_blue) && $stable(avg_green)
			&& $stable(avg_red) && $stable(frames) && $stable(eof))
		else $error("result changed while stalled");

endmodule

bind temporal_frame_average tfa_checker u_tfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (averages.valid),
	.out_ready (averages.ready),
	.avg_blue  (averages.avg_blue),
	.avg_green (averages.avg_green),
	.avg_red   (averages.avg_red),
	.frames    (averages.frames_averaged),
	.eof       (averages.end_of_frame)
);

`default_nettype wire
